// File: rtl/ppt_pkg.sv
// shared types, request and status codes for the pulse phase tracker
package ppt_pkg;

	localparam logic [1:0] REQ_PULSE = 2'd0;
	localparam logic [1:0] REQ_QUERY = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_CYCLE = 3'd1;
	localparam logic [2:0] ST_NO_PULSE  = 3'd2;
	localparam logic [2:0] ST_BEFORE    = 3'd3;
	localparam logic [2:0] ST_STALE     = 3'd4;

	localparam logic [31:0] STALE_LIMIT_RESET = 32'd2000000;
	localparam logic [10:0] US_PER_MS = 11'd1000;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [63:0] time_us;
		logic [15:0] cycle_ms;
	} in_t;

	typedef struct packed {
		logic        ok;
		logic [9:0]  phase_ms;
		logic [2:0]  status;
		logic [31:0] pulse_total;
	} out_t;

	// true for the cycle lengths that divide one second evenly
	function automatic logic cycle_fits(input logic [15:0] c);
		logic fits;
		unique case (c)
			16'd1, 16'd2, 16'd4, 16'd5, 16'd8, 16'd10, 16'd20, 16'd25,
			16'd40, 16'd50, 16'd100, 16'd125, 16'd200, 16'd250, 16'd500,
			16'd1000: fits = 1'b1;
			default: fits = 1'b0;
		endcase
		return fits;
	endfunction

endpackage

// File: rtl/pulse_phase_tracker.sv
// pulse phase tracker: digit-serial pulse age and phase computation
//
//  channel  direction  payload        handshake
//  in       input      ppt_pkg::in_t  in_valid / in_stall
//  out      output     ppt_pkg::out_t out_valid / out_stall
//  cfg      input      stale limit    cfg_we (write only)
//
// pulse, clear and unused request codes are taken in idle and give no transfer
// a query whose cycle or pulse check fails goes straight to done; other queries
// run a digit-serial 4-bit subtract and compare, then, unless now is before the
// pulse or the age is stale, a bit-serial divide by 1000 with a running mod-cycle
// remainder; the result sits in an output register, so a stall on out only holds
// in once the next query finishes; reset clears control state, limit is 2000000
module pulse_phase_tracker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  ppt_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output ppt_pkg::out_t  out_data,
	input  logic           cfg_we,
	input  logic [31:0]    cfg_wdata
);
	import ppt_pkg::*;

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SUB  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	localparam logic [4:0] SUB_LAST = 5'd15;
	localparam logic [4:0] DIV_LAST = 5'd31;

	logic [1:0]  state_q;
	logic [4:0]  cnt_q;

	// tracker state
	logic [63:0] last_pulse_q;
	logic        pulse_seen_q;
	logic [31:0] pulse_count_q;
	logic [31:0] stale_q;

	// query working registers
	logic [63:0] t_q;        // current time, turns into the age digit by digit
	logic [63:0] lp_q;       // pulse time, shifted out a digit per cycle
	logic [31:0] lim_q;      // stale limit, shifts in zeros above bit 31
	logic        borrow_q;
	logic        gt_q;       // age so far greater than limit so far
	logic [9:0]  cyc_q;
	logic [9:0]  rem_q;      // remainder of age by 1000
	logic [9:0]  rcyc_q;     // quotient modulo cycle
	logic [2:0]  status_q;
	logic [31:0] total_q;

	logic        out_valid_q;
	out_t        out_q;

	logic        in_xfer;
	logic        query;
	logic        out_load;

	logic [4:0]  diff5;
	logic [3:0]  dig;
	logic [3:0]  lim_dig;
	logic        gt_next;

	logic [10:0] trial;
	logic        qbit;
	logic [9:0]  rem_next;
	logic [10:0] trial_c;
	logic [9:0]  rcyc_next;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign query     = in_xfer && (in_data.req_type == REQ_QUERY);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// one 4-bit digit of now minus pulse, lsb digit first
	assign diff5   = {1'b0, t_q[3:0]} - {1'b0, lp_q[3:0]} - {4'd0, borrow_q};
	assign dig     = diff5[3:0];
	assign lim_dig = lim_q[3:0];
	// a higher digit decides, equal digits keep the lower verdict
	assign gt_next = (dig > lim_dig) || ((dig == lim_dig) && gt_q);

	// restoring divide by 1000, msb of the 32-bit age first
	assign trial    = {rem_q, t_q[31]};
	assign qbit     = (trial >= US_PER_MS);
	assign rem_next = qbit ? 10'(trial - US_PER_MS) : trial[9:0];
	// quotient bits fold into a remainder by the cycle length
	assign trial_c   = {rcyc_q, qbit};
	assign rcyc_next = (trial_c >= {1'b0, cyc_q}) ? 10'(trial_c - {1'b0, cyc_q})
	                                              : trial_c[9:0];

	// stale limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_q <= STALE_LIMIT_RESET;
		end else if (cfg_we) begin
			stale_q <= cfg_wdata;
		end
	end

	// pulse and clear update the tracker at transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pulse_q  <= '0;
			pulse_seen_q  <= 1'b0;
			pulse_count_q <= '0;
		end else if (in_xfer) begin
			if (in_data.req_type == REQ_PULSE) begin
				last_pulse_q  <= in_data.time_us;
				pulse_seen_q  <= 1'b1;
				pulse_count_q <= pulse_count_q + 32'd1;
			end else if (in_data.req_type == REQ_CLEAR) begin
				last_pulse_q  <= '0;
				pulse_seen_q  <= 1'b0;
				pulse_count_q <= '0;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (query) begin
						if (!cycle_fits(in_data.cycle_ms) || !pulse_seen_q) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SUB;
						end
					end
				end
				S_SUB: begin
					if (cnt_q == SUB_LAST) begin
						cnt_q <= '0;
						// borrow out means now before pulse
						if (diff5[4] || gt_next) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_DIV;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_DIV: begin
					if (cnt_q == DIV_LAST) begin
						cnt_q   <= '0;
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// query datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				t_q      <= in_data.time_us;
				lp_q     <= last_pulse_q;
				lim_q    <= stale_q;
				borrow_q <= 1'b0;
				gt_q     <= 1'b0;
				cyc_q    <= in_data.cycle_ms[9:0];
				rem_q    <= '0;
				rcyc_q   <= '0;
				total_q  <= pulse_count_q;
				priority if (!cycle_fits(in_data.cycle_ms)) begin
					status_q <= ST_BAD_CYCLE;
				end else if (!pulse_seen_q) begin
					status_q <= ST_NO_PULSE;
				end else begin
					status_q <= ST_OK;
				end
			end
			S_SUB: begin
				t_q      <= {dig, t_q[63:4]};
				lp_q     <= {4'd0, lp_q[63:4]};
				lim_q    <= {4'd0, lim_q[31:4]};
				borrow_q <= diff5[4];
				gt_q     <= gt_next;
				if (cnt_q == SUB_LAST) begin
					priority if (diff5[4]) begin
						status_q <= ST_BEFORE;
					end else if (gt_next) begin
						status_q <= ST_STALE;
					end else begin
						status_q <= ST_OK;
					end
				end
			end
			S_DIV: begin
				t_q    <= {t_q[62:0], 1'b0};
				rem_q  <= rem_next;
				rcyc_q <= rcyc_next;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.ok          <= (status_q == ST_OK);
			out_q.phase_ms    <= (status_q == ST_OK) ? rcyc_q : '0;
			out_q.status      <= status_q;
			out_q.pulse_total <= total_q;
		end
	end

`ifndef ASSERT_OFF
	a_ok_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.ok == (out_q.status == ST_OK)))
		else $error("ok flag disagrees with status");

	a_phase_zero_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.ok) |-> (out_q.phase_ms == '0))
		else $error("phase not zero on failed query");

	a_div_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> ((rem_q < US_PER_MS) && (rcyc_q < cyc_q)))
		else $error("divider remainder out of range");

	a_bad_cycle_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(query && !cycle_fits(in_data.cycle_ms)) |=>
		((state_q == S_DONE) && (status_q == ST_BAD_CYCLE)))
		else $error("bad cycle query not answered at once");

	a_sub_length: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SUB) && (cnt_q == SUB_LAST)) |=> (state_q != S_SUB))
		else $error("subtract phase overran");
`endif

endmodule
